FILE: rtl/flu_pkg.sv
// Package for the usage-ordered free list: widths, action codes, node word layout
// and the result record handed from the controller to the output stage.
// No dependencies.
package flu_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int LINK_W        = 8;
  localparam int FLAG_W        = 3;
  localparam int WORD_W        = FLAG_W + LINK_W;
  localparam int CNT_W         = 9;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 9'd256;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_SETTAIL = 2'd2;
  localparam logic [1:0] ACT_SWEEP   = 2'd3;

  // flag bits within the 3-bit flag field
  localparam int F_USED = 0;
  localparam int F_LOCK = 1;
  localparam int F_PEND = 2;

  typedef struct packed {
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
    logic              used;
    logic              lock;
    logic              pend;
    logic [LINK_W-1:0] tail;
    logic              corrupt;
  } res_t;

endpackage

FILE: rtl/free_list_usage_reorder.sv
// Usage-ordered free list, top level: node_count register, node and next-link RAMs,
// controller and output register. Depends on flu_pkg, flu_ram, flu_ctrl, flu_oreg.
// A sweep walks back from the tail, keeping some nodes in place and moving others to the
// tail (with or without a successor); one item in flight, so the next item is accepted
// only once the last result has been taken by the output register.
// Reset: tail pointer 0, node_count 256, node memories keep contents (no clearing).
module free_list_usage_reorder #(
  parameter int MAX_NODES = flu_pkg::MAX_NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [flu_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [flu_pkg::LINK_W-1:0] node_index,
  input  logic [flu_pkg::LINK_W-1:0] prev_link,
  input  logic [flu_pkg::LINK_W-1:0] next_link,
  input  logic                       used_mark,
  input  logic                       lock_mark,
  input  logic                       pend_mark,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [flu_pkg::LINK_W-1:0] out_prev,
  output logic [flu_pkg::LINK_W-1:0] out_next,
  output logic                       out_used,
  output logic                       out_lock,
  output logic                       out_pend,
  output logic [flu_pkg::LINK_W-1:0] tail_now,
  output logic                       list_corrupt
);

  localparam int AW = $clog2(MAX_NODES);

  logic [flu_pkg::CNT_W-1:0]  node_count;
  logic                       p_we;
  logic [AW-1:0]              p_waddr;
  logic [flu_pkg::WORD_W-1:0] p_wdata;
  logic                       p_re;
  logic [AW-1:0]              p_raddr;
  logic [flu_pkg::WORD_W-1:0] p_rdata;
  logic                       n_we;
  logic [AW-1:0]              n_waddr;
  logic [flu_pkg::LINK_W-1:0] n_wdata;
  logic                       n_re;
  logic [AW-1:0]              n_raddr;
  logic [flu_pkg::LINK_W-1:0] n_rdata;
  flu_pkg::res_t              res;
  logic                       res_valid;
  logic                       res_take;
  flu_pkg::res_t              out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= flu_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  flu_ram #(
    .WIDTH (flu_pkg::WORD_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  flu_ram #(
    .WIDTH (flu_pkg::LINK_W),
    .DEPTH (MAX_NODES)
  ) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  flu_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .node_index (node_index),
    .prev_link  (prev_link),
    .next_link  (next_link),
    .used_mark  (used_mark),
    .lock_mark  (lock_mark),
    .pend_mark  (pend_mark),
    .node_count (node_count),
    .p_we       (p_we),
    .p_waddr    (p_waddr),
    .p_wdata    (p_wdata),
    .p_re       (p_re),
    .p_raddr    (p_raddr),
    .p_rdata    (p_rdata),
    .n_we       (n_we),
    .n_waddr    (n_waddr),
    .n_wdata    (n_wdata),
    .n_re       (n_re),
    .n_raddr    (n_raddr),
    .n_rdata    (n_rdata),
    .res        (res),
    .res_valid  (res_valid),
    .res_take   (res_take)
  );

  flu_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_prev     = out_res.prev;
  assign out_next     = out_res.next;
  assign out_used     = out_res.used;
  assign out_lock     = out_res.lock;
  assign out_pend     = out_res.pend;
  assign tail_now     = out_res.tail;
  assign list_corrupt = out_res.corrupt;

endmodule

FILE: rtl/flu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module flu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/flu_oreg.sv
// Output register stage: holds one result item toward the output channel.
// Depends on flu_pkg.
module flu_oreg (
  input  logic          clk,
  input  logic          rst,
  input  flu_pkg::res_t res,
  input  logic          res_valid,
  output logic          res_take,
  output logic          out_valid,
  input  logic          out_stall,
  output flu_pkg::res_t out_res
);

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

endmodule

FILE: rtl/flu_ctrl.sv
// Controller: decodes items, runs the sweep sequencer over the node and next-link
// memories (read, modify, write back) and holds the tail pointer. Depends on flu_pkg.
module flu_ctrl #(
  parameter int MAX_NODES = flu_pkg::MAX_NODES_DEF,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [flu_pkg::LINK_W-1:0]       node_index,
  input  logic [flu_pkg::LINK_W-1:0]       prev_link,
  input  logic [flu_pkg::LINK_W-1:0]       next_link,
  input  logic                             used_mark,
  input  logic                             lock_mark,
  input  logic                             pend_mark,
  input  logic [flu_pkg::CNT_W-1:0]        node_count,
  // node memory: {pend, lock, used, prev}
  output logic                             p_we,
  output logic [AW-1:0]                    p_waddr,
  output logic [flu_pkg::WORD_W-1:0]       p_wdata,
  output logic                             p_re,
  output logic [AW-1:0]                    p_raddr,
  input  logic [flu_pkg::WORD_W-1:0]       p_rdata,
  // next-link memory
  output logic                             n_we,
  output logic [AW-1:0]                    n_waddr,
  output logic [flu_pkg::LINK_W-1:0]       n_wdata,
  output logic                             n_re,
  output logic [AW-1:0]                    n_raddr,
  input  logic [flu_pkg::LINK_W-1:0]       n_rdata,
  output flu_pkg::res_t                    res,
  output logic                             res_valid,
  input  logic                             res_take
);

  localparam int LW = flu_pkg::LINK_W;
  localparam int SW = 20;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDW  = 9'b000000010,
    S_SCHK = 9'b000000100,
    S_SEVL = 9'b000001000,
    S_NRD  = 9'b000010000,
    S_MV1  = 9'b000100000,
    S_MV2  = 9'b001000000,
    S_MV3  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                    state;
  logic [1:0]                act_q;
  logic [LW-1:0]             tail;
  logic [LW-1:0]             j;
  logic [LW-1:0]             u;
  logic [LW-1:0]             m_q;
  logic [LW-1:0]             n_q;
  logic [flu_pkg::FLAG_W-1:0] fl_q;
  logic [flu_pkg::FLAG_W-1:0] nfl_q;
  logic [flu_pkg::CNT_W-1:0] budget;
  logic                      phase2;
  logic [LW-1:0]             r_prev;
  logic [LW-1:0]             r_next;
  logic [flu_pkg::FLAG_W-1:0] r_flags;
  logic                      r_corrupt;

  logic [flu_pkg::FLAG_W-1:0] rd_fl;
  logic [LW-1:0]             rd_prev;
  logic                      rd_used;
  logic                      rd_keep;
  logic [LW-1:0]             p_wa8;
  logic [LW-1:0]             p_ra8;
  logic [LW-1:0]             n_wa8;
  logic [LW-1:0]             n_ra8;

  // index modulo MAX_NODES by restoring subtraction
  function automatic logic [AW-1:0] slot(input logic [LW-1:0] x);
    logic [SW-1:0] r;
    r = {{(SW-LW){1'b0}}, x};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (SW'(MAX_NODES) << k)) begin
        r = r - (SW'(MAX_NODES) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign rd_fl   = p_rdata[flu_pkg::WORD_W-1:LW];
  assign rd_prev = p_rdata[LW-1:0];
  assign rd_used = rd_fl[flu_pkg::F_USED];
  assign rd_keep = rd_fl[flu_pkg::F_LOCK] | rd_fl[flu_pkg::F_PEND];

  assign in_stall = (state != S_IDLE);

  always_comb begin
    p_we    = 1'b0;
    p_wa8   = j;
    p_wdata = '0;
    p_re    = 1'b0;
    p_ra8   = j;
    n_we    = 1'b0;
    n_wa8   = j;
    n_wdata = '0;
    n_re    = 1'b0;
    n_ra8   = j;
    case (state)
      S_IDLE: begin
        if (in_valid && action == flu_pkg::ACT_WRITE) begin
          p_we    = 1'b1;
          p_wa8   = node_index;
          p_wdata = {pend_mark, lock_mark, used_mark, prev_link};
          n_we    = 1'b1;
          n_wa8   = node_index;
          n_wdata = next_link;
        end else if (in_valid && action == flu_pkg::ACT_READ) begin
          p_re  = 1'b1;
          p_ra8 = node_index;
          n_re  = 1'b1;
          n_ra8 = node_index;
        end
      end
      S_SCHK: begin
        if (j != '0) begin
          p_re = 1'b1;
          n_re = 1'b1;
        end
      end
      S_SEVL: begin
        if (budget != '0) begin
          if (!phase2 && rd_used) begin
            if (!rd_keep) begin
              p_we    = 1'b1;
              p_wdata = {rd_fl[flu_pkg::F_PEND], rd_fl[flu_pkg::F_LOCK], 1'b0, rd_prev};
            end
          end else if (rd_used && n_rdata != '0) begin
            p_re  = 1'b1;
            p_ra8 = n_rdata;
          end
        end
      end
      S_MV1: begin
        if (n_q != '0) begin
          p_we    = 1'b1;
          p_wa8   = n_q;
          p_wdata = {nfl_q, m_q};
        end
        if (m_q != '0) begin
          n_we    = 1'b1;
          n_wa8   = m_q;
          n_wdata = n_q;
        end
      end
      S_MV2: begin
        p_we    = 1'b1;
        p_wdata = {fl_q[flu_pkg::F_PEND], fl_q[flu_pkg::F_LOCK],
                   fl_q[flu_pkg::F_LOCK] | fl_q[flu_pkg::F_PEND], u};
        n_we    = 1'b1;
        n_wdata = '0;
      end
      S_MV3: begin
        n_we    = 1'b1;
        n_wa8   = u;
        n_wdata = j;
      end
      default: begin
      end
    endcase
  end

  assign p_waddr = slot(p_wa8);
  assign p_raddr = slot(p_ra8);
  assign n_waddr = slot(n_wa8);
  assign n_raddr = slot(n_ra8);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q     <= action;
            r_prev    <= '0;
            r_next    <= '0;
            r_flags   <= '0;
            r_corrupt <= 1'b0;
            case (action)
              flu_pkg::ACT_WRITE: begin
                state <= S_DONE;
              end
              flu_pkg::ACT_READ: begin
                state <= S_RDW;
              end
              flu_pkg::ACT_SETTAIL: begin
                tail  <= node_index;
                state <= S_DONE;
              end
              default: begin
                j      <= tail;
                u      <= tail;
                budget <= node_count;
                phase2 <= 1'b0;
                state  <= S_SCHK;
              end
            endcase
          end
        end
        S_RDW: begin
          r_prev  <= rd_prev;
          r_flags <= rd_fl;
          r_next  <= n_rdata;
          state   <= S_DONE;
        end
        S_SCHK: begin
          if (j == '0) begin
            tail  <= u;
            state <= S_DONE;
          end else begin
            state <= S_SEVL;
          end
        end
        S_SEVL: begin
          if (budget == '0) begin
            r_corrupt <= 1'b1;
            state     <= S_DONE;
          end else begin
            budget <= budget - 9'd1;
            if (!phase2 && rd_used) begin
              j     <= rd_prev;
              state <= S_SCHK;
            end else begin
              phase2 <= 1'b1;
              if (rd_used) begin
                m_q   <= rd_prev;
                n_q   <= n_rdata;
                fl_q  <= rd_fl;
                state <= (n_rdata != '0) ? S_NRD : S_MV1;
              end else begin
                j     <= rd_prev;
                state <= S_SCHK;
              end
            end
          end
        end
        S_NRD: begin
          nfl_q <= rd_fl;
          state <= S_MV1;
        end
        S_MV1: begin
          state <= S_MV2;
        end
        S_MV2: begin
          state <= S_MV3;
        end
        S_MV3: begin
          u     <= j;
          j     <= m_q;
          state <= S_SCHK;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid   = (state == S_DONE);
  assign res.prev    = r_prev;
  assign res.next    = r_next;
  assign res.used    = r_flags[flu_pkg::F_USED];
  assign res.lock    = r_flags[flu_pkg::F_LOCK];
  assign res.pend    = r_flags[flu_pkg::F_PEND];
  assign res.tail    = tail;
  assign res.corrupt = r_corrupt;

  a_no_p_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(p_we && p_re && p_waddr == p_raddr))
    else $error("node memory read and write to same entry");

  a_no_n_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(n_we && n_re && n_waddr == n_raddr))
    else $error("next-link memory read and write to same entry");

  a_append_tail_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_MV2) |-> (u != '0))
    else $error("append with null tail");

  a_budget_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEVL && budget != '0) |=> (budget == $past(budget) - 9'd1))
    else $error("sweep budget not decremented");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && act_q != flu_pkg::ACT_READ) |-> (res.prev == '0 && res.next == '0))
    else $error("link fields set on non-read item");

endmodule

FILE: tb/tb_free_list_usage_reorder.sv
// Testbench for free_list_usage_reorder: directed and random node writes, reads,
// tail moves and sweeps, checked item by item against an in-bench list model.
// Depends on flu_pkg and the free_list_usage_reorder RTL only.
module tb_free_list_usage_reorder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS    = 1550;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]                 act;
    logic [flu_pkg::LINK_W-1:0] idx;
    logic [flu_pkg::LINK_W-1:0] pv;
    logic [flu_pkg::LINK_W-1:0] nx;
    logic                       u;
    logic                       l;
    logic                       p;
  } node_cmd_t;

  class usage_list_board;
    logic [flu_pkg::LINK_W-1:0] prev_q [256];
    logic [flu_pkg::LINK_W-1:0] next_q [256];
    logic [flu_pkg::FLAG_W-1:0] flag_q [256];
    bit                         written [256];
    logic [flu_pkg::LINK_W-1:0] tail;
    logic [flu_pkg::CNT_W-1:0]  node_budget;
    bit                         stray;
    flu_pkg::res_t              pending_results [$];
    int                         errors;

    function new();
      tail = '0;
      node_budget = flu_pkg::NODE_COUNT_RST;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void touch(logic [flu_pkg::LINK_W-1:0] k);
      if (!written[k]) stray = 1'b1;
    endfunction

    function void release_node(logic [flu_pkg::LINK_W-1:0] k);
      if (!flag_q[k][flu_pkg::F_LOCK] && !flag_q[k][flu_pkg::F_PEND])
        flag_q[k][flu_pkg::F_USED] = 1'b0;
    endfunction

    // returns 1 when the step budget runs out
    function bit walk_back();
      logic [flu_pkg::LINK_W-1:0] j, u, m, nx;
      int unsigned left;
      j = tail;
      u = tail;
      left = 32'(node_budget);
      stray = 1'b0;
      while (j != 0) begin
        touch(j);
        if (!flag_q[j][flu_pkg::F_USED]) break;
        if (left == 0) return 1'b1;
        left--;
        release_node(j);
        j = prev_q[j];
      end
      while (j != 0) begin
        touch(j);
        if (left == 0) return 1'b1;
        left--;
        m = prev_q[j];
        if (flag_q[j][flu_pkg::F_USED]) begin
          nx = next_q[j];
          touch(u);
          if (nx != 0) begin
            touch(nx);
            prev_q[nx] = m;
          end
          if (m != 0) begin
            touch(m);
            next_q[m] = nx;
          end
          prev_q[j] = u;
          next_q[j] = '0;
          next_q[u] = j;
          u = j;
          release_node(j);
        end
        j = m;
      end
      tail = u;
      return 1'b0;
    endfunction

    // dry run: a sweep must only touch nodes that hold written contents
    function bit sweep_is_safe();
      logic [flu_pkg::LINK_W-1:0] p_save [256];
      logic [flu_pkg::LINK_W-1:0] n_save [256];
      logic [flu_pkg::FLAG_W-1:0] f_save [256];
      logic [flu_pkg::LINK_W-1:0] t_save;
      p_save = prev_q;
      n_save = next_q;
      f_save = flag_q;
      t_save = tail;
      void'(walk_back());
      prev_q = p_save;
      next_q = n_save;
      flag_q = f_save;
      tail = t_save;
      return !stray;
    endfunction

    function void apply_item(node_cmd_t c);
      flu_pkg::res_t r;
      r = '0;
      case (c.act)
        flu_pkg::ACT_WRITE: begin
          prev_q[c.idx] = c.pv;
          next_q[c.idx] = c.nx;
          flag_q[c.idx] = {c.p, c.l, c.u};
          written[c.idx] = 1'b1;
        end
        flu_pkg::ACT_READ: begin
          r.prev = prev_q[c.idx];
          r.next = next_q[c.idx];
          r.used = flag_q[c.idx][flu_pkg::F_USED];
          r.lock = flag_q[c.idx][flu_pkg::F_LOCK];
          r.pend = flag_q[c.idx][flu_pkg::F_PEND];
        end
        flu_pkg::ACT_SETTAIL: tail = c.idx;
        default: r.corrupt = walk_back();
      endcase
      r.tail = tail;
      pending_results.push_back(r);
    endfunction

    function void compare(string field, logic [flu_pkg::LINK_W-1:0] want,
                          logic [flu_pkg::LINK_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(flu_pkg::res_t got);
      flu_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result item with none expected");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare("out_prev", want.prev, got.prev);
      compare("out_next", want.next, got.next);
      compare("out_used", flu_pkg::LINK_W'(want.used), flu_pkg::LINK_W'(got.used));
      compare("out_lock", flu_pkg::LINK_W'(want.lock), flu_pkg::LINK_W'(got.lock));
      compare("out_pend", flu_pkg::LINK_W'(want.pend), flu_pkg::LINK_W'(got.pend));
      compare("tail_now", want.tail, got.tail);
      compare("list_corrupt", flu_pkg::LINK_W'(want.corrupt),
              flu_pkg::LINK_W'(got.corrupt));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [flu_pkg::CNT_W-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 action = flu_pkg::ACT_WRITE;
  logic [flu_pkg::LINK_W-1:0] node_index = '0;
  logic [flu_pkg::LINK_W-1:0] prev_link = '0;
  logic [flu_pkg::LINK_W-1:0] next_link = '0;
  logic                       used_mark = 1'b0;
  logic                       lock_mark = 1'b0;
  logic                       pend_mark = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [flu_pkg::LINK_W-1:0] out_prev;
  logic [flu_pkg::LINK_W-1:0] out_next;
  logic                       out_used;
  logic                       out_lock;
  logic                       out_pend;
  logic [flu_pkg::LINK_W-1:0] tail_now;
  logic                       list_corrupt;

  usage_list_board lists;
  int sent = 0;
  int calm_items = 0;
  int hold_req = 0;
  int stall_left = 0;
  int calm_left = 0;
  int stall_pick;
  int idle_cycles = 0;

  free_list_usage_reorder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .node_index   (node_index),
    .prev_link    (prev_link),
    .next_link    (next_link),
    .used_mark    (used_mark),
    .lock_mark    (lock_mark),
    .pend_mark    (pend_mark),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_prev     (out_prev),
    .out_next     (out_next),
    .out_used     (out_used),
    .out_lock     (out_lock),
    .out_pend     (out_pend),
    .tail_now     (tail_now),
    .list_corrupt (list_corrupt)
  );

  always #1 clk = ~clk;

  // receiver: short and long stalls, calm stretches, and requested hold-offs
  always @(posedge clk) begin
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left == 0 && calm_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) calm_left = $urandom_range(1, 6);
      else if (stall_pick < 62) calm_left = $urandom_range(30, 120);
      else if (stall_pick < 95) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(10, 50);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      calm_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      lists.check_result({out_prev, out_next, out_used, out_lock, out_pend, tail_now,
                          list_corrupt});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_items = $urandom_range(15, 50);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic node_cmd_t make_cmd(logic [1:0] a, logic [flu_pkg::LINK_W-1:0] k);
    node_cmd_t c;
    c.act = a;
    c.idx = k;
    c.pv = flu_pkg::LINK_W'($urandom_range(0, 255));
    c.nx = flu_pkg::LINK_W'($urandom_range(0, 255));
    c.u = 1'($urandom_range(0, 1));
    c.l = 1'($urandom_range(0, 1));
    c.p = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_item(node_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= c.act;
    node_index <= c.idx;
    prev_link  <= c.pv;
    next_link  <= c.nx;
    used_mark  <= c.u;
    lock_mark  <= c.l;
    pend_mark  <= c.p;
    do @(posedge clk); while (in_stall !== 1'b0);
    lists.apply_item(c);
    sent++;
  endtask

  task automatic write_node(logic [flu_pkg::LINK_W-1:0] k, logic [flu_pkg::LINK_W-1:0] pv,
                            logic [flu_pkg::LINK_W-1:0] nx, logic u, logic l, logic p);
    node_cmd_t c;
    c = make_cmd(flu_pkg::ACT_WRITE, k);
    c.pv = pv;
    c.nx = nx;
    c.u = u;
    c.l = l;
    c.p = p;
    send_item(c);
  endtask

  task automatic write_random_node(logic [flu_pkg::LINK_W-1:0] k);
    write_node(k, flu_pkg::LINK_W'($urandom_range(0, 255)),
               flu_pkg::LINK_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // a never-written node is written instead of read
  task automatic read_node(logic [flu_pkg::LINK_W-1:0] k);
    if (lists.written[k]) send_item(make_cmd(flu_pkg::ACT_READ, k));
    else write_random_node(k);
  endtask

  task automatic set_tail(logic [flu_pkg::LINK_W-1:0] k);
    send_item(make_cmd(flu_pkg::ACT_SETTAIL, k));
  endtask

  task automatic sweep_list();
    if (lists.sweep_is_safe())
      send_item(make_cmd(flu_pkg::ACT_SWEEP, flu_pkg::LINK_W'($urandom_range(0, 255))));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (lists.pending_results.size() != 0);
  endtask

  task automatic write_budget(logic [flu_pkg::CNT_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lists.node_budget = v;
  endtask

  // doubly linked list on distinct random nodes, then tail, sweep and reads
  task automatic build_and_sweep();
    logic [flu_pkg::LINK_W-1:0] order [255];
    logic [flu_pkg::LINK_W-1:0] t;
    int len, r, s;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(2, 10);
    else if (r < 96) len = $urandom_range(11, 40);
    else len = $urandom_range(60, 255);
    for (int i = 0; i < 255; i++) order[i] = flu_pkg::LINK_W'(i + 1);
    for (int i = 0; i < len; i++) begin
      s = $urandom_range(i, 254);
      t = order[i];
      order[i] = order[s];
      order[s] = t;
    end
    for (int i = 0; i < len; i++)
      write_node(order[i], (i == 0) ? 8'd0 : order[i-1], (i == len - 1) ? 8'd0 : order[i+1],
                 $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 15,
                 $urandom_range(0, 99) < 15);
    if ($urandom_range(0, 99) < 15) set_tail(order[$urandom_range(0, len - 1)]);
    else set_tail(order[len-1]);
    sweep_list();
    repeat ($urandom_range(0, 3)) read_node(order[$urandom_range(0, len - 1)]);
    if ($urandom_range(0, 2) == 0) sweep_list();
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 5))
      0, 1: write_random_node(flu_pkg::LINK_W'($urandom_range(0, 255)));
      2: read_node(flu_pkg::LINK_W'($urandom_range(0, 255)));
      3: set_tail(flu_pkg::LINK_W'($urandom_range(0, 255)));
      default: sweep_list();
    endcase
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic pressure_burst();
    calm_items = 12;
    hold_req = $urandom_range(200, 400);
    repeat (12) noise_item();
  endtask

  task automatic directed_items();
    write_node(8'd0, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    write_node(8'd255, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    read_node(8'd0);
    read_node(8'd255);
    set_tail(8'd0);
    sweep_list();
    // 1 <- 2 <- 3 <- 4 <- 5: used tail run, unused stop node, locked and plain movers
    write_node(8'd1, 8'd0, 8'd2, 1'b1, 1'b0, 1'b0);
    write_node(8'd2, 8'd1, 8'd3, 1'b1, 1'b1, 1'b0);
    write_node(8'd3, 8'd2, 8'd4, 1'b0, 1'b0, 1'b0);
    write_node(8'd4, 8'd3, 8'd5, 1'b1, 1'b0, 1'b0);
    write_node(8'd5, 8'd4, 8'd0, 1'b1, 1'b0, 1'b1);
    set_tail(8'd5);
    sweep_list();
    read_node(8'd1);
    read_node(8'd2);
    read_node(8'd5);
    write_node(8'd6, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
    read_node(8'd6);
    write_budget(9'd1);
    sweep_list();
    write_budget(9'd0);
    sweep_list();
    write_budget(flu_pkg::NODE_COUNT_RST);
    set_tail(8'd255);
    sweep_list();
  endtask

  initial begin
    logic [flu_pkg::CNT_W-1:0] budget_seq [7];
    int next_cfg, cfg_pos, r;
    budget_seq = '{9'd511, 9'd1, 9'd256, 9'd0, 9'd2, 9'd255, 9'd128};
    lists = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    pressure_burst();
    drain();
    next_cfg = sent + $urandom_range(120, 220);
    cfg_pos = 0;
    while (sent < ITEMS) begin
      if (sent >= next_cfg) begin
        if (cfg_pos < 7) write_budget(budget_seq[cfg_pos]);
        else write_budget(flu_pkg::CNT_W'($urandom_range(1, 300)));
        cfg_pos++;
        next_cfg = sent + $urandom_range(120, 220);
      end
      r = $urandom_range(0, 99);
      if (r < 55) build_and_sweep();
      else if (r < 99) noise_item();
      else pressure_burst();
    end
    drain();
    repeat (20) @(posedge clk);
    if (lists.errors == 0 && lists.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
